// ===== hdl/ats_pkg.sv =====
// Package: shared constants, types and codes of the eligibility shaper
`timescale 1ns / 1ps
package ats_pkg;
  localparam int unsigned MaxInstances = 16;
  localparam int unsigned StreamSlots  = 256;
  localparam int unsigned InstW  = $clog2(MaxInstances);
  localparam int unsigned CountW = $clog2(MaxInstances + 1);
  localparam int unsigned SlotW  = $clog2(StreamSlots);
  localparam int unsigned TimeW  = 62;
  localparam int unsigned RateW  = 39;
  localparam int unsigned BurstW = 32;
  localparam int unsigned ResW   = 40;
  localparam int unsigned CfgW   = 40;
  localparam int unsigned NumW   = 64;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [29:0] NsPerS = 30'd1000000000;

  typedef enum logic [1:0] {
    OP_SHAPE  = 2'd0,
    OP_CREATE = 2'd1,
    OP_MAP    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LATE     = 3'd1,
    ST_ZERO     = 3'd2,
    ST_MAPPED   = 3'd3,
    ST_NO_INST  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAX_RES = 2'd0,
    CFG_RATE    = 2'd1,
    CFG_BURST   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TimeW-1:0]  now_ns;
    logic [15:0]       frame_bytes;
    logic [7:0]        stream_handle;
    logic [2:0]        frame_priority;
    logic [RateW-1:0]  new_rate_bps;
    logic [BurstW-1:0] new_burst_bits;
    logic [3:0]        target_instance;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TimeW-1:0] eligible_at_ns;
    logic [2:0]       out_priority;
    logic [3:0]       created_instance;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [RateW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NumW-1:0]  quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOOK, S_MUL1, S_DIV1, S_MUL2, S_DIV2,
    S_SUM, S_DECIDE, S_OUT
  } state_e;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction
endpackage

// ===== hdl/ats_if.sv =====
// Interface: valid/ready channel carrying one item
`timescale 1ns / 1ps
interface ats_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ats_div.sv =====
// Module: radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ats_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ats_pkg::div_req_t req_i,
  output ats_pkg::div_rsp_t rsp_o
);
  localparam int unsigned NW = ats_pkg::NumW;
  localparam int unsigned DW = ats_pkg::RateW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW+1:0] trial;

  // load on start, then shift one numerator bit into the partial remainder
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NW-1]} - {2'b00, den_q};
      if (!trial[DW+1]) begin
        rem_d = trial[DW:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DW-1:0], quo_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

// ===== hdl/ats_eligibility_shaper_core.sv =====
// Module: top level of the token-bucket eligibility shaper
`timescale 1ns / 1ps
//  channel   | direction | payload
//  in_ch     | sink      | ats_pkg::in_item_t (operation .. target_instance)
//  out_ch    | source    | ats_pkg::out_item_t (status .. created_instance)
//  cfg_*     | write     | index 0..2, 40-bit data
// A shape item runs two 64-step divisions by the rate, which share one
// bit-serial divider, plus memory read and update steps. Create, map and
// unused items go from the lookup step to the output step; a zero-rate shape stops after the first multiply step.
// Reset clears the binding valid bits, counters and default/group times.
// The result sits in an output register; a finished item waits in the last
// step until that register is free, and the next item is taken after it.
module ats_eligibility_shaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ats_if.sink        in_ch,
  ats_if.source      out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [ats_pkg::CfgW-1:0] cfg_data_i
);
  localparam int unsigned TW = ats_pkg::TimeW;
  localparam int unsigned RW = ats_pkg::RateW;
  localparam int unsigned BW = ats_pkg::BurstW;
  localparam int unsigned IW = ats_pkg::InstW;
  localparam int unsigned NW = ats_pkg::NumW;

  // configuration registers
  logic [ats_pkg::ResW-1:0] max_res_q;
  logic [RW-1:0] def_rate_q;
  logic [BW-1:0] def_burst_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_res_q <= 40'd10000000; def_rate_q <= 39'd100000000; def_burst_q <= 32'd12288;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ats_pkg::CFG_MAX_RES: max_res_q <= cfg_data_i;
        ats_pkg::CFG_RATE:    def_rate_q <= cfg_data_i[RW-1:0];
        ats_pkg::CFG_BURST:   def_burst_q <= cfg_data_i[BW-1:0];
        default: ;
      endcase
    end
  end

  // memories: instance table and stream binding
  logic [RW+BW+TW-1:0] inst_mem [ats_pkg::MaxInstances];
  logic [IW-1:0]       bind_mem [ats_pkg::StreamSlots];
  logic [ats_pkg::StreamSlots-1:0] bind_vld_q;
  logic [RW+BW+TW-1:0] inst_rd_q;
  logic [IW-1:0]       bind_rd_q;
  logic inst_we, bind_we;
  logic [IW-1:0] inst_waddr, inst_raddr;
  logic [RW+BW+TW-1:0] inst_wdata;

  ats_pkg::state_e state_q, state_d;
  ats_pkg::in_item_t item_q;
  ats_pkg::out_item_t res_q, res_d;
  ats_pkg::out_item_t out_q, out_d;
  logic [ats_pkg::CountW-1:0] created_q, created_d;
  logic [TW-1:0] def_empty_q, def_empty_d, group_q, group_d;
  logic bound_q, bound_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [RW-1:0] rate_q, rate_d;
  logic [BW-1:0] burst_q, burst_d;
  logic [TW-1:0] empty_q, empty_d;
  logic [NW-1:0] prod_q, prod_d;
  logic [TW-1:0] sched_q, sched_d, full_q, full_d, elig_q, elig_d;
  logic out_vld_q, out_vld_d;
  ats_pkg::div_req_t dreq;
  ats_pkg::div_rsp_t drsp;
  logic [TW-1:0] dur, lim, nempty;

  always_ff @(posedge clk_i) begin
    if (inst_we) inst_mem[inst_waddr] <= inst_wdata;
    if (bind_we) bind_mem[item_q.stream_handle] <= item_q.target_instance[IW-1:0];
    inst_rd_q <= inst_mem[inst_raddr];
    bind_rd_q <= bind_mem[item_q.stream_handle];
  end

  assign inst_raddr = bind_rd_q;

  ats_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign in_ch.ready = (state_q == ats_pkg::S_IDLE);
  assign out_ch.valid = out_vld_q;
  assign out_ch.data = out_q;

  // quotient saturates into the time width
  assign dur = (drsp.quo[NW-1:TW] != '0) ? ats_pkg::TimeMax : drsp.quo[TW-1:0];
  assign lim = ats_pkg::sat_add(item_q.now_ns, {{(TW-40){1'b0}}, max_res_q});
  assign nempty = (elig_q < full_q) ? sched_q : ats_pkg::sat_add(sched_q, elig_q - full_q);

  // sequencer
  always_comb begin
    state_d = state_q; res_d = res_q; out_d = out_q; created_d = created_q;
    def_empty_d = def_empty_q; group_d = group_q; bound_d = bound_q; idx_d = idx_q;
    rate_d = rate_q; burst_d = burst_q; empty_d = empty_q; prod_d = prod_q;
    sched_d = sched_q; full_d = full_q; elig_d = elig_q; out_vld_d = out_vld_q;
    dreq = '0; inst_we = 1'b0; bind_we = 1'b0; inst_waddr = idx_q; inst_wdata = '0;
    if (out_ch.valid && out_ch.ready) out_vld_d = 1'b0;
    unique case (state_q)
      ats_pkg::S_IDLE: if (in_ch.valid) state_d = ats_pkg::S_READ;
      ats_pkg::S_READ: state_d = ats_pkg::S_LOOK;  // binding read in flight
      ats_pkg::S_LOOK: begin
        res_d = '0;
        state_d = ats_pkg::S_OUT;
        case (ats_pkg::op_e'(item_q.operation))
          ats_pkg::OP_SHAPE: begin
            bound_d = bind_vld_q[item_q.stream_handle];
            idx_d = bind_rd_q;
            state_d = ats_pkg::S_MUL1;
          end
          ats_pkg::OP_CREATE: begin
            if (created_q >= ats_pkg::CountW'(ats_pkg::MaxInstances)) begin
              res_d.status = ats_pkg::ST_FULL;
            end else begin
              inst_we = 1'b1; inst_waddr = created_q[IW-1:0];
              inst_wdata = {item_q.new_rate_bps, item_q.new_burst_bits, item_q.now_ns};
              res_d.created_instance = 4'(created_q);
              created_d = created_q + 1'b1;
            end
          end
          ats_pkg::OP_MAP: begin
            if (bind_vld_q[item_q.stream_handle]) res_d.status = ats_pkg::ST_MAPPED;
            else if ({1'b0, item_q.target_instance} >= 5'(created_q))
              res_d.status = ats_pkg::ST_NO_INST;
            else bind_we = 1'b1;
          end
          default: ;
        endcase
      end
      ats_pkg::S_MUL1: begin
        // instance read has landed
        rate_d  = bound_q ? inst_rd_q[RW+BW+TW-1:BW+TW] : def_rate_q;
        burst_d = bound_q ? inst_rd_q[BW+TW-1:TW] : def_burst_q;
        empty_d = bound_q ? inst_rd_q[TW-1:0] : def_empty_q;
        prod_d  = NW'({item_q.frame_bytes, 3'b000}) * NW'(ats_pkg::NsPerS);
        state_d = ats_pkg::S_DIV1;
        if (rate_d == '0) begin
          res_d.status = ats_pkg::ST_ZERO; state_d = ats_pkg::S_OUT;
        end else begin
          dreq.start = 1'b1; dreq.num = prod_d + NW'(rate_d[RW-1:1]); dreq.den = rate_d;
        end
      end
      ats_pkg::S_DIV1: if (drsp.done) begin
        sched_d = ats_pkg::sat_add(empty_q, dur);
        prod_d = NW'(burst_q) * NW'(ats_pkg::NsPerS);
        state_d = ats_pkg::S_MUL2;
      end
      ats_pkg::S_MUL2: begin
        dreq.start = 1'b1; dreq.num = prod_q + NW'(rate_q[RW-1:1]); dreq.den = rate_q;
        state_d = ats_pkg::S_DIV2;
      end
      ats_pkg::S_DIV2: if (drsp.done) begin
        full_d = ats_pkg::sat_add(empty_q, dur);
        state_d = ats_pkg::S_SUM;
      end
      ats_pkg::S_SUM: begin
        elig_d = item_q.now_ns;
        if (group_q > elig_d) elig_d = group_q;
        if (sched_q > elig_d) elig_d = sched_q;
        state_d = ats_pkg::S_DECIDE;
      end
      ats_pkg::S_DECIDE: begin
        state_d = ats_pkg::S_OUT;
        if (elig_q > lim) res_d.status = ats_pkg::ST_LATE;
        else begin
          group_d = elig_q;
          if (bound_q) begin
            inst_we = 1'b1; inst_wdata = {rate_q, burst_q, nempty};
          end else def_empty_d = nempty;
          res_d.eligible_at_ns = elig_q;
          res_d.out_priority = item_q.frame_priority;
        end
      end
      // hand the result to the output register once it is free
      ats_pkg::S_OUT: if (!out_vld_q || out_ch.ready) begin
        out_d = res_q; out_vld_d = 1'b1; state_d = ats_pkg::S_IDLE;
      end
      default: state_d = ats_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ats_pkg::S_IDLE; out_vld_q <= 1'b0; created_q <= '0;
      def_empty_q <= '0; group_q <= '0; bind_vld_q <= '0;
    end else begin
      state_q <= state_d; out_vld_q <= out_vld_d; created_q <= created_d;
      def_empty_q <= def_empty_d; group_q <= group_d;
      if (bind_we) bind_vld_q[item_q.stream_handle] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
    res_q <= res_d; out_q <= out_d; bound_q <= bound_d; idx_q <= idx_d; rate_q <= rate_d;
    burst_q <= burst_d; empty_q <= empty_d; prod_q <= prod_d;
    sched_q <= sched_d; full_q <= full_d; elig_q <= elig_d;
  end

  // checks
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= ats_pkg::CountW'(ats_pkg::MaxInstances)) else $error("instance count overflow");
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> (state_q == ats_pkg::S_MUL1 || state_q == ats_pkg::S_MUL2))
    else $error("divider started out of sequence");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ch.ready) |=> (out_vld_q && $stable(out_q)))
    else $error("pending result changed");
endmodule

// ===== dv/ats_eligibility_shaper_core_tb.sv =====
// Testbench: self-checking random and directed regression of the eligibility shaper core
`timescale 1ns / 1ps
module ats_eligibility_shaper_core_tb;
  import ats_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  ats_if #(.T(in_item_t))  in_ch ();
  ats_if #(.T(out_item_t)) out_ch ();

  ats_eligibility_shaper_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  localparam int unsigned CycleLimit = 1000000;

  // shadow copy of the shaper state and registers
  logic [ResW-1:0]   sh_max_res;
  logic [RateW-1:0]  sh_def_rate;
  logic [BurstW-1:0] sh_def_burst;
  logic [RateW-1:0]  sh_rate   [MaxInstances];
  logic [BurstW-1:0] sh_burst  [MaxInstances];
  logic [TimeW-1:0]  sh_empty  [MaxInstances];
  int unsigned       sh_created;
  logic              sh_bound  [StreamSlots];
  logic [InstW-1:0]  sh_inst   [StreamSlots];
  logic [TimeW-1:0]  sh_def_empty;
  logic [TimeW-1:0]  sh_group;

  in_item_t    pend_q[$];
  out_item_t   elig_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  logic        idle_on;
  logic [TimeW-1:0] tnow;

  // saturating time sum
  function automatic logic [TimeW-1:0] time_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  // bits * 1e9 / rate, rounded half up
  function automatic logic [TimeW-1:0] bits_to_ns(logic [63:0] bits, logic [RateW-1:0] rate);
    logic [63:0] q;
    q = (bits * 64'd1000000000 + 64'(rate >> 1)) / 64'(rate);
    return q[TimeW-1:0];
  endfunction

  // eligibility result of one item, updating the shadow state
  function automatic out_item_t shape_result(in_item_t it);
    out_item_t r;
    logic bound;
    logic [InstW-1:0] idx;
    logic [RateW-1:0] rate;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0] empty, sched, full, elig, nempty;
    r = '0;
    case (op_e'(it.operation))
      OP_SHAPE: begin
        bound = sh_bound[it.stream_handle];
        idx   = bound ? sh_inst[it.stream_handle] : '0;
        rate  = bound ? sh_rate[idx]  : sh_def_rate;
        burst = bound ? sh_burst[idx] : sh_def_burst;
        empty = bound ? sh_empty[idx] : sh_def_empty;
        if (rate == '0) begin
          r.status = ST_ZERO;
        end else begin
          sched = time_sum(empty, bits_to_ns(64'(it.frame_bytes) * 8, rate));
          full  = time_sum(empty, bits_to_ns(64'(burst), rate));
          elig  = it.now_ns;
          if (sh_group > elig) elig = sh_group;
          if (sched > elig) elig = sched;
          if (elig > time_sum(it.now_ns, TimeW'(sh_max_res))) begin
            r.status = ST_LATE;
          end else begin
            nempty = (elig < full) ? sched : time_sum(sched, elig - full);
            sh_group = elig;
            if (bound) sh_empty[idx] = nempty;
            else sh_def_empty = nempty;
            r.eligible_at_ns = elig;
            r.out_priority   = it.frame_priority;
          end
        end
      end
      OP_CREATE: begin
        if (sh_created >= MaxInstances) begin
          r.status = ST_FULL;
        end else begin
          sh_rate[sh_created]  = it.new_rate_bps;
          sh_burst[sh_created] = it.new_burst_bits;
          sh_empty[sh_created] = it.now_ns;
          r.created_instance   = sh_created[3:0];
          sh_created++;
        end
      end
      OP_MAP: begin
        if (sh_bound[it.stream_handle]) r.status = ST_MAPPED;
        else if (it.target_instance >= sh_created) r.status = ST_NO_INST;
        else begin
          sh_bound[it.stream_handle] = 1'b1;
          sh_inst[it.stream_handle]  = it.target_instance;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_item(op_e op, logic [TimeW-1:0] now, logic [15:0] bytes,
                           logic [7:0] handle, logic [2:0] prio, logic [RateW-1:0] rate,
                           logic [BurstW-1:0] burst, logic [3:0] target);
    in_item_t it;
    it.operation       = op;
    it.now_ns          = now;
    it.frame_bytes     = bytes;
    it.stream_handle   = handle;
    it.frame_priority  = prio;
    it.new_rate_bps    = rate;
    it.new_burst_bits  = burst;
    it.target_instance = target;
    pend_q.push_back(it);
  endtask

  // wait until every queued item has gone in and every result has come out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_ch.valid || elig_q.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_MAX_RES: sh_max_res   = val[ResW-1:0];
      CFG_RATE:    sh_def_rate  = val[RateW-1:0];
      default:     sh_def_burst = val[BurstW-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [RateW-1:0] any_rate();
    return RateW'({$urandom(), $urandom()}) % 39'd400000000001;
  endfunction

  // random mix: mostly realistic frames on an advancing clock
  task automatic random_items(int unsigned n, logic wide_now);
    int unsigned sel;
    logic [TimeW-1:0] now;
    logic [15:0] bytes;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      tnow = time_sum(tnow, TimeW'($urandom_range(20000)));
      now = wide_now ? TimeW'({$urandom(), $urandom()}) : tnow;
      bytes = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(1522, 64));
      if (sel < 70)
        push_item(OP_SHAPE, now, bytes, 8'($urandom()), 3'($urandom()), any_rate(),
                  $urandom(), 4'($urandom()));
      else if (sel < 85)
        push_item(OP_MAP, now, bytes, 8'($urandom()), 3'($urandom()), any_rate(),
                  $urandom(), 4'($urandom()));
      else if (sel < 93)
        push_item(OP_CREATE, now, bytes, 8'($urandom()), 3'($urandom()), any_rate(),
                  $urandom(), 4'($urandom()));
      else
        push_item(OP_NONE, now, bytes, 8'($urandom()), 3'($urandom()), any_rate(),
                  $urandom(), 4'($urandom()));
      if (i % 100 == 99) wait_drained();
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // driver: presents pending items, holding each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) elig_q.push_back(shape_result(in_ch.data));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pend_q.size() != 0 && !(idle_on && $urandom_range(99) < 8)) begin
          in_ch.data  <= pend_q.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and field-by-field check
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 8);
      if (out_ch.valid && out_ch.ready) begin
        if (elig_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_ch.data);
        end else begin
          want = elig_q.pop_front();
          if (out_ch.data.status !== want.status
              || out_ch.data.eligible_at_ns !== want.eligible_at_ns
              || out_ch.data.out_priority !== want.out_priority
              || out_ch.data.created_instance !== want.created_instance) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d elig=%0d pr=%0d id=%0d got st=%0d elig=%0d pr=%0d id=%0d",
                       want.status, want.eligible_at_ns, want.out_priority,
                       want.created_instance, out_ch.data.status,
                       out_ch.data.eligible_at_ns, out_ch.data.out_priority,
                       out_ch.data.created_instance);
          end
        end
      end
    end
  end

  initial begin
    logic [RateW-1:0] inst_rates [MaxInstances];
    mismatches   = 0;
    cycles       = 0;
    idle_on      = 1'b1;
    tnow         = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_MAX_RES;
    cfg_data_i   = '0;
    sh_max_res   = 40'd10000000;
    sh_def_rate  = 39'd100000000;
    sh_def_burst = 32'd12288;
    sh_created   = 0;
    sh_def_empty = '0;
    sh_group     = '0;
    for (int i = 0; i < StreamSlots; i++) begin
      sh_bound[i] = 1'b0;
      sh_inst[i]  = '0;
    end
    for (int i = 0; i < MaxInstances; i++) begin
      sh_rate[i] = '0; sh_burst[i] = '0; sh_empty[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default instance, unbound map, fill the table, map checks
    push_item(OP_SHAPE, 62'd0, 16'd0, 8'd0, 3'd7, '0, '0, '0);
    push_item(OP_SHAPE, 62'd1000, 16'hFFFF, 8'hFF, 3'd5, '0, '0, '0);
    push_item(OP_MAP, 62'd1000, 16'd0, 8'd3, 3'd0, '0, '0, 4'd0);
    push_item(OP_NONE, 62'd2000, 16'hFFFF, 8'hFF, 3'd7, '1, '1, '1);
    inst_rates[0] = 39'd100000000;
    inst_rates[1] = 39'd0;
    inst_rates[2] = 39'd400000000000;
    inst_rates[3] = 39'd1;
    for (int i = 4; i < MaxInstances; i++) inst_rates[i] = 39'($urandom_range(2000000000, 1000000));
    for (int i = 0; i < MaxInstances; i++)
      push_item(OP_CREATE, 62'd3000, '0, '0, '0, inst_rates[i],
                (i == 2) ? 32'hFFFFFFFF : 32'd12288, '0);
    push_item(OP_CREATE, 62'd3000, '0, '0, '0, 39'd5, 32'd5, '0);
    wait_drained();
    push_item(OP_MAP, 62'd4000, '0, 8'd1, '0, '0, '0, 4'd1);
    push_item(OP_MAP, 62'd4000, '0, 8'd2, '0, '0, '0, 4'd2);
    push_item(OP_MAP, 62'd4000, '0, 8'd3, '0, '0, '0, 4'd3);
    push_item(OP_MAP, 62'd4000, '0, 8'd1, '0, '0, '0, 4'd0);
    push_item(OP_SHAPE, 62'd5000, 16'd64, 8'd1, 3'd2, '0, '0, '0);
    push_item(OP_SHAPE, 62'd5000, 16'hFFFF, 8'd2, 3'd3, '0, '0, '0);
    push_item(OP_SHAPE, 62'd5000, 16'd1500, 8'd3, 3'd4, '0, '0, '0);
    tnow = 62'd6000;
    wait_drained();

    // random phases across register settings
    random_items(200, 1'b0);
    wait_drained();
    write_reg(CFG_MAX_RES, {ResW{1'b1}});
    write_reg(CFG_RATE, 40'd400000000000);
    write_reg(CFG_BURST, 40'hFFFFFFFF);
    idle_on = 1'b0;
    random_items(150, 1'b0);
    wait_drained();
    idle_on = 1'b1;
    write_reg(CFG_MAX_RES, '0);
    write_reg(CFG_RATE, '0);
    write_reg(CFG_BURST, '0);
    random_items(120, 1'b0);
    wait_drained();
    write_reg(CFG_MAX_RES, 40'd1000000);
    write_reg(CFG_RATE, 40'd1000000000);
    write_reg(CFG_BURST, 40'd100000);
    random_items(180, 1'b0);
    wait_drained();

    // extremes of the clock: saturation near the top of the time range
    write_reg(CFG_MAX_RES, {ResW{1'b1}});
    write_reg(CFG_RATE, 40'd1);
    push_item(OP_SHAPE, TimeMax, 16'hFFFF, 8'd200, 3'd6, '0, '0, '0);
    push_item(OP_SHAPE, TimeMax - 62'd5, 16'd64, 8'd201, 3'd1, '0, '0, '0);
    wait_drained();
    write_reg(CFG_RATE, 40'd400000000000);
    random_items(80, 1'b1);
    wait_drained();

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && elig_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
